// ----- src/arffp_pkg.sv -----
// shared types, constants and controller/datapath interface structs for the
// address range first-fit placer; no dependencies
package arffp_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int ENTRY_COUNT_W   = 7;

  localparam logic [63:0] KERN_LOW  = 64'h0000_ffff_8000_0000;
  localparam logic [63:0] KERN_HIGH = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] USER_LOW  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] USER_HIGH = 64'h0000_7fff_ffff_ffff;

  // result status codes
  localparam logic [1:0] ST_MAPPED  = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // memory read address select
  localparam logic [1:0] RD_IDX  = 2'd0;
  localparam logic [1:0] RD_NEXT = 2'd1;
  localparam logic [1:0] RD_K    = 2'd2;

  typedef struct packed {
    logic        place_anywhere;
    logic [63:0] requested_vaddr;
    logic [63:0] region_size;
    logic [31:0] object_tag;
  } in_item_t;

  typedef struct packed {
    logic [63:0]              chosen_vaddr;
    logic [1:0]               status;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] len;
    logic [31:0] tag;
  } entry_t;

  typedef struct packed {
    logic       latch_req;
    logic       idx_clr;
    logic       idx_inc;
    logic [1:0] rd_sel;
    logic       calc_end;
    logic       calc_top;
    logic       pos_from_idx;   // fixed request: pos = idx, addr = requested
    logic       pos_from_next;  // placement hit: pos = idx + 1, addr = end
    logic       pos_zero_lo;    // empty table: pos = 0, addr = window low
    logic       k_init;
    logic       k_dec;
    logic       wr_shift;
    logic       wr_new;
    logic       set_status;
    logic [1:0] status_code;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic anywhere;
    logic idx_lt_count;
    logic next_lt_count;
    logic base_lt_req;
    logic top_ge_hi;
    logic fit;
    logic shift_needed;
    logic shift_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- src/arffp_datapath.sv -----
// entry table memory, scan/shift counters, address arithmetic and result register
// depends on arffp_pkg
module arffp_datapath #(
  parameter int MAX_ENTRIES = arffp_pkg::MAX_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  arffp_pkg::in_item_t  in_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic                 cfg_data,
  input  arffp_pkg::dp_cmd_t   cmd,
  output arffp_pkg::dp_stat_t  stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output arffp_pkg::out_item_t out_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  arffp_pkg::entry_t   mem [MAX_ENTRIES];
  arffp_pkg::entry_t   rdata_r;
  arffp_pkg::in_item_t req_r;
  arffp_pkg::out_item_t out_data_r;

  logic [CW-1:0] idx_r, pos_r, k_r, count_r;
  logic [63:0]   end_r, top_r, next_base_r, addr_r;
  logic [1:0]    status_r;
  logic          kernel_space_r;
  logic          out_valid_r;

  logic [CW-1:0] idx_plus, k_plus;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  arffp_pkg::entry_t wr_data;
  logic [63:0]   win_lo, win_hi;

  assign idx_plus = idx_r + CW'(1);
  assign k_plus   = k_r + CW'(1);
  assign win_lo   = kernel_space_r ? arffp_pkg::KERN_LOW  : arffp_pkg::USER_LOW;
  assign win_hi   = kernel_space_r ? arffp_pkg::KERN_HIGH : arffp_pkg::USER_HIGH;

  always_comb begin
    case (cmd.rd_sel)
      arffp_pkg::RD_IDX:  rd_addr = idx_r[AW-1:0];
      arffp_pkg::RD_NEXT: rd_addr = idx_plus[AW-1:0];
      arffp_pkg::RD_K:    rd_addr = k_r[AW-1:0];
      default:            rd_addr = idx_r[AW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = cmd.wr_shift | cmd.wr_new;
    wr_addr = cmd.wr_shift ? k_plus[AW-1:0] : pos_r[AW-1:0];
    if (cmd.wr_shift) begin
      wr_data = rdata_r;
    end else begin
      wr_data.base = addr_r;
      wr_data.len  = req_r.region_size;
      wr_data.tag  = req_r.object_tag;
    end
  end

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_r <= in_data;
    end
    if (cmd.calc_end) begin
      end_r <= rdata_r.base + rdata_r.len;
    end
    if (cmd.calc_top) begin
      top_r       <= end_r + req_r.region_size;
      next_base_r <= rdata_r.base;
    end
    if (cmd.pos_from_idx) begin
      addr_r <= req_r.requested_vaddr;
    end else if (cmd.pos_from_next) begin
      addr_r <= end_r;
    end else if (cmd.pos_zero_lo) begin
      addr_r <= win_lo;
    end
    if (cmd.pos_from_idx) begin
      pos_r <= idx_r;
    end else if (cmd.pos_from_next) begin
      pos_r <= idx_plus;
    end else if (cmd.pos_zero_lo) begin
      pos_r <= '0;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_plus;
    end
    if (cmd.k_init) begin
      k_r <= count_r - CW'(1);
    end else if (cmd.k_dec) begin
      k_r <= k_r - CW'(1);
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.load_out) begin
      out_data_r.chosen_vaddr <= (status_r == arffp_pkg::ST_MAPPED) ? addr_r : 64'd0;
      out_data_r.status       <= status_r;
      out_data_r.entry_count  <= arffp_pkg::ENTRY_COUNT_W'(count_r);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r        <= '0;
      kernel_space_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cmd.wr_new) begin
        count_r <= count_r + CW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        kernel_space_r <= cfg_data;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.full          = (count_r == CW'(MAX_ENTRIES));
    stat.empty         = (count_r == '0);
    stat.anywhere      = req_r.place_anywhere;
    stat.idx_lt_count  = (idx_r < count_r);
    stat.next_lt_count = (idx_plus < count_r);
    stat.base_lt_req   = (rdata_r.base < req_r.requested_vaddr);
    stat.top_ge_hi     = (top_r >= win_hi);
    stat.fit           = (end_r >= win_lo) && (!stat.next_lt_count || next_base_r >= top_r);
    stat.shift_needed  = (pos_r < count_r);
    stat.shift_last    = (k_r == pos_r);
    stat.out_free      = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/arffp_ctrl.sv -----
// request sequencer: scan, shift and insert steps over the entry table
// depends on arffp_pkg, drives arffp_datapath through dp_cmd_t
module arffp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  arffp_pkg::dp_stat_t stat,
  output arffp_pkg::dp_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_DISP  = 12'b0000_0000_0010,
    S_FRD   = 12'b0000_0000_0100,
    S_FCMP  = 12'b0000_0000_1000,
    S_ARD   = 12'b0000_0001_0000,
    S_AEND  = 12'b0000_0010_0000,
    S_ATOP  = 12'b0000_0100_0000,
    S_AEVAL = 12'b0000_1000_0000,
    S_PREP  = 12'b0001_0000_0000,
    S_SRD   = 12'b0010_0000_0000,
    S_SWR   = 12'b0100_0000_0000,
    S_INS   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;  // result ready to move into the output register

  assign in_ready = (state_r == S_IDLE) && !done_r;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    cmd       = '0;
    cmd.rd_sel = arffp_pkg::RD_IDX;
    if (done_r && stat.out_free) begin
      cmd.load_out = 1'b1;
      done_nxt     = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        cmd.set_status  = 1'b1;
        cmd.status_code = arffp_pkg::ST_MAPPED;
        cmd.idx_clr     = 1'b1;
        if (stat.full) begin
          cmd.status_code = arffp_pkg::ST_FULL;
          done_nxt        = 1'b1;
          state_nxt       = S_IDLE;
        end else if (!stat.anywhere) begin
          state_nxt = S_FRD;
        end else if (stat.empty) begin
          cmd.pos_zero_lo = 1'b1;
          state_nxt       = S_INS;
        end else begin
          state_nxt = S_ARD;
        end
      end
      S_FRD: begin
        cmd.rd_sel = arffp_pkg::RD_IDX;
        if (stat.idx_lt_count) begin
          state_nxt = S_FCMP;
        end else begin
          cmd.pos_from_idx = 1'b1;
          state_nxt        = S_PREP;
        end
      end
      S_FCMP: begin
        if (stat.base_lt_req) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_FRD;
        end else begin
          cmd.pos_from_idx = 1'b1;
          state_nxt        = S_PREP;
        end
      end
      S_ARD: begin
        cmd.rd_sel = arffp_pkg::RD_IDX;
        state_nxt  = S_AEND;
      end
      S_AEND: begin
        cmd.calc_end = 1'b1;
        cmd.rd_sel   = arffp_pkg::RD_NEXT;
        state_nxt    = S_ATOP;
      end
      S_ATOP: begin
        cmd.calc_top = 1'b1;
        state_nxt    = S_AEVAL;
      end
      S_AEVAL: begin
        if (stat.top_ge_hi) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = arffp_pkg::ST_NO_ROOM;
          done_nxt        = 1'b1;
          state_nxt       = S_IDLE;
        end else if (stat.fit) begin
          cmd.pos_from_next = 1'b1;
          state_nxt         = S_PREP;
        end else if (stat.next_lt_count) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_ARD;
        end else begin
          cmd.set_status  = 1'b1;
          cmd.status_code = arffp_pkg::ST_NO_ROOM;
          done_nxt        = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_PREP: begin
        if (stat.shift_needed) begin
          cmd.k_init = 1'b1;
          state_nxt  = S_SRD;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_SRD: begin
        cmd.rd_sel = arffp_pkg::RD_K;
        state_nxt  = S_SWR;
      end
      S_SWR: begin
        // move entry k up one slot
        cmd.wr_shift = 1'b1;
        if (stat.shift_last) begin
          state_nxt = S_INS;
        end else begin
          cmd.k_dec = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_INS: begin
        cmd.wr_new = 1'b1;
        done_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
        done_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

// ----- src/address_range_first_fit_placer.sv -----
// Sorted address range table with first-fit placement. One request is worked at a time:
// a fixed address reads and compares each entry scanned, a placement reads each entry,
// forms its end and end + size and then evaluates the fit, each entry moved up to open the
// insert slot is read and written back, and the accept, dispatch, insert and result-load
// steps come on top; a request on a full table answers straight from dispatch. The scan
// and shift go one entry at a time through the single read port and single write port of
// the entry table memory; the longest request is a placement that fits only after the last entry.
// A finished result sits in the output register while the next item is taken in.
// kernel_space must be written through the cfg port only while the block is idle; the block
// itself does not enforce this. The table needs no clearing pass after reset.
module address_range_first_fit_placer #(
  parameter int MAX_ENTRIES = arffp_pkg::MAX_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  arffp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output arffp_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  arffp_pkg::dp_cmd_t  cmd;
  arffp_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  arffp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  arffp_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- src/arffp_checker.sv -----
// port-level checks for the address range first-fit placer, bound to the top level
// depends on arffp_pkg
module arffp_checker #(
  parameter int MAX_ENTRIES = arffp_pkg::MAX_ENTRIES_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input arffp_pkg::out_item_t out_data
);

  localparam logic [arffp_pkg::ENTRY_COUNT_W-1:0] FULL_COUNT =
    arffp_pkg::ENTRY_COUNT_W'(MAX_ENTRIES);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // failures report a zero address
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != arffp_pkg::ST_MAPPED |-> out_data.chosen_vaddr == 64'd0)
    else $error("nonzero address on failed request");

  // table full goes with a full count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == arffp_pkg::ST_FULL |-> out_data.entry_count == FULL_COUNT)
    else $error("full status with wrong entry count");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status code");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

endmodule

bind address_range_first_fit_placer arffp_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_arffp_checker (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// testbench for address_range_first_fit_placer: directed and random map requests,
// checked against a behavioral range table kept here; needs src/arffp_pkg.sv and the RTL
module tb_top;
  import arffp_pkg::*;

  localparam int  TBL_DEPTH   = MAX_ENTRIES_DEF;
  localparam int  DRAIN_WAIT  = 6 * TBL_DEPTH + 16;
  localparam longint CYCLE_LIMIT = 4_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  // table as the block should hold it
  logic [63:0] tbl_base [0:TBL_DEPTH-1];
  logic [63:0] tbl_len  [0:TBL_DEPTH-1];
  logic [31:0] tbl_tag  [0:TBL_DEPTH-1];
  int          n_used = 0;
  logic        kern_mode = 1'b0;

  out_item_t   pending_results [$];
  out_item_t   head_r;
  int          n_errors = 0;
  int          stall_pct = 0;
  longint      n_cycles = 0;

  address_range_first_fit_placer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // works out one map request; commit updates the table
  function automatic out_item_t map_request(input in_item_t it, input bit commit);
    logic [63:0] lo, hi, fin, top, addr;
    logic [1:0]  st;
    int          pos, i, j, cnt;
    bit          ok, stop;
    out_item_t   r;
    addr = '0;
    st   = ST_MAPPED;
    pos  = 0;
    ok   = 1'b0;
    stop = 1'b0;
    lo   = kern_mode ? KERN_LOW : USER_LOW;
    hi   = kern_mode ? KERN_HIGH : USER_HIGH;
    if (n_used >= TBL_DEPTH) begin
      st = ST_FULL;
    end else if (!it.place_anywhere) begin
      while (pos < n_used && tbl_base[pos] < it.requested_vaddr) pos++;
      addr = it.requested_vaddr;
      ok   = 1'b1;
    end else if (n_used == 0) begin
      addr = lo;
      ok   = 1'b1;
    end else begin
      st = ST_NO_ROOM;
      for (i = 0; i < n_used && !stop; i++) begin
        fin = tbl_base[i] + tbl_len[i];
        top = fin + it.region_size;
        if (top >= hi) begin
          stop = 1'b1;
        end else if (fin >= lo && (i + 1 >= n_used || tbl_base[i+1] >= top)) begin
          addr = fin;
          pos  = i + 1;
          ok   = 1'b1;
          st   = ST_MAPPED;
          stop = 1'b1;
        end
      end
    end
    cnt = n_used + (ok ? 1 : 0);
    if (ok && commit) begin
      for (j = n_used; j > pos; j--) begin
        tbl_base[j] = tbl_base[j-1];
        tbl_len[j]  = tbl_len[j-1];
        tbl_tag[j]  = tbl_tag[j-1];
      end
      tbl_base[pos] = addr;
      tbl_len[pos]  = it.region_size;
      tbl_tag[pos]  = it.object_tag;
      n_used        = cnt;
    end
    r.chosen_vaddr = (st == ST_MAPPED) ? addr : '0;
    r.status       = st;
    r.entry_count  = cnt[ENTRY_COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.place_anywhere = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 3))
      0: it.requested_vaddr = rand64();
      1: it.requested_vaddr = USER_LOW + (rand64() & 64'h0000_00ff_ffff_fff0);
      2: it.requested_vaddr = KERN_LOW + (rand64() & 64'h0000_0000_7fff_fff0);
      default: it.requested_vaddr = $urandom_range(0, 1) ? ~(rand64() & 64'hffff)
                                                          : (rand64() & 64'hffff);
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2: it.region_size = rand64() & 64'hffff;
      3, 4:    it.region_size = rand64() >> $urandom_range(0, 63);
      5:       it.region_size = rand64();
      default: begin
        case ($urandom_range(0, 3))
          0: it.region_size = '0;
          1: it.region_size = '1;
          2: it.region_size = 64'd1;
          default: it.region_size = USER_HIGH;
        endcase
      end
    endcase
    it.object_tag = $urandom;
    return it;
  endfunction

  // result check, one item per accepted handshake
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, out_data);
        n_errors++;
      end else begin
        head_r = pending_results.pop_front();
        if (out_data.chosen_vaddr !== head_r.chosen_vaddr) begin
          $display("%0t: chosen_vaddr expected %h actual %h", $time,
                   head_r.chosen_vaddr, out_data.chosen_vaddr);
          n_errors++;
        end
        if (out_data.status !== head_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   head_r.status, out_data.status);
          n_errors++;
        end
        if (out_data.entry_count !== head_r.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time,
                   head_r.entry_count, out_data.entry_count);
          n_errors++;
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(map_request(it, 1'b1));
  endtask

  task automatic send_req(input logic anywhere, input logic [63:0] vaddr,
                          input logic [63:0] size, input logic [31:0] tag);
    in_item_t it;
    it.place_anywhere  = anywhere;
    it.requested_vaddr = vaddr;
    it.region_size     = size;
    it.object_tag      = tag;
    send_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_kernel_space(input logic v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    kern_mode = v;
  endtask

  // first placement on the empty table; its end wraps below the window so the
  // next placement runs out of entries
  task automatic test_empty_table();
    write_kernel_space(1'b1);
    send_req(1'b1, '1, 64'h20 - KERN_LOW, 32'hffff_ffff);
    send_req(1'b1, 64'h0, 64'h100, 32'h0000_0001);
    wait_idle();
  endtask

  task automatic test_fixed_insert();
    send_req(1'b0, 64'h0, 64'h0, 32'h0);
    send_req(1'b0, '1, '1, 32'h5a5a_a5a5);
    // equal base goes in front of the existing entry
    send_req(1'b0, KERN_LOW, 64'h40, 32'h1234_5678);
    wait_idle();
  endtask

  task automatic test_placement();
    send_req(1'b1, rand64(), 64'h0, 32'ha5a5_5a5a);
    // end + size lands exactly on the kernel upper bound
    send_req(1'b1, rand64(), 64'h1, $urandom);
    write_kernel_space(1'b0);
    send_req(1'b1, rand64(), 64'h1000, $urandom);
    send_req(1'b0, 64'h0000_0002_0000_0000, 64'h1000, $urandom);
    send_req(1'b1, rand64(), 64'h1000, $urandom);
    send_req(1'b1, rand64(), 64'h0, $urandom);
    wait_idle();
  endtask

  task automatic test_no_room();
    send_req(1'b1, rand64(), USER_HIGH - 64'h0000_0002_0000_1000, $urandom);
    send_req(1'b1, rand64(), USER_HIGH - 64'h0000_0002_0000_1001, $urandom);
    send_req(1'b1, rand64(), '1, $urandom);
    wait_idle();
  endtask

  // random requests; few are allowed to map so the table fills slowly and
  // most placements scan deep before failing
  task automatic test_random_phase(input int n_items, input int idle_pct, input int stall_i,
                                   input int count_cap, input logic kern_val);
    in_item_t  it;
    out_item_t trial;
    bit        want_map;
    int        k, tries;
    write_kernel_space(kern_val);
    stall_pct = stall_i;
    for (k = 0; k < n_items; k++) begin
      want_map = (n_used < count_cap) && ($urandom_range(0, 99) < 6);
      it    = rand_item();
      trial = map_request(it, 1'b0);
      tries = 1;
      while (((trial.status == ST_MAPPED) != want_map) && tries < 24) begin
        it    = rand_item();
        trial = map_request(it, 1'b0);
        tries++;
      end
      while ($urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      send_item(it);
      if ($urandom_range(0, 63) == 0) wait_idle();
    end
    wait_idle();
  endtask

  task automatic test_full_table();
    in_item_t it;
    int       k;
    write_kernel_space(1'($urandom_range(0, 1)));
    stall_pct = 15;
    while (n_used < TBL_DEPTH) begin
      it = rand_item();
      it.place_anywhere = 1'b0;
      send_item(it);
    end
    for (k = 0; k < 80; k++) begin
      while ($urandom_range(0, 99) < 15) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      send_item(rand_item());
    end
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_fixed_insert();
    test_placement();
    test_no_room();
    test_random_phase(335, 0, 0, 22, 1'b0);
    test_random_phase(335, 80, 0, 35, 1'b1);
    test_random_phase(335, 0, 80, 48, 1'b0);
    test_random_phase(335, 15, 15, 60, 1'($urandom_range(0, 1)));
    test_full_table();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- address_range_first_fit_placer.f -----
src/arffp_pkg.sv
src/arffp_datapath.sv
src/arffp_ctrl.sv
src/address_range_first_fit_placer.sv
src/arffp_checker.sv
verif/tb_top.sv
